@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, compiled out when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// condition holds in the same cycle as the trigger
`define ASSERT_SAME(label, clk, rst_n, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error("assertion failed");

// condition holds in the cycle after the trigger
`define ASSERT_NEXT(label, clk, rst_n, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("assertion failed");

`else

`define ASSERT_SAME(label, clk, rst_n, trig, cond)
`define ASSERT_NEXT(label, clk, rst_n, trig, cond)

`endif

`endif

@@ design/rsf_pkg.sv @@
// ----------------------------------------------------------------------------
// rsf_pkg
// Shared types, widths and constants of the restriction site fragmenter.
// ----------------------------------------------------------------------------
package rsf_pkg;

    localparam int MAX_MOTIF_DEF    = 8;
    localparam int MAX_READ_LEN_DEF = 65536;

    localparam int BASE_W      = 8;
    localparam int PATTERN_W   = 64;
    localparam int BYTE_IDX_W  = 3;
    localparam int CFG_LEN_W   = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int START_W     = 16;
    localparam int LEN_W       = 17;

    // register map
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_MOTIF_PATTERN = 2'd0;
    localparam t_cfg_idx CFG_MOTIF_LENGTH  = 2'd1;
    localparam t_cfg_idx CFG_CUT_OFFSET    = 2'd2;

    // "GATC", first base in the low byte
    localparam logic [PATTERN_W-1:0] MOTIF_GATC     = 64'h0000_0000_4354_4147;
    localparam logic [CFG_LEN_W-1:0] MOTIF_LEN_RST  = 4'd4;
    localparam logic [CFG_LEN_W-1:0] CUT_OFFSET_RST = 4'd0;

    // output queue
    localparam int OQ_DEPTH = 4;
    localparam int OQ_PTR_W = 2;
    localparam int OQ_CNT_W = 3;

    typedef struct packed {
        logic [START_W-1:0] frag_start;
        logic [LEN_W-1:0]   frag_length;
        logic               final_fragment;
        logic               run_last;
    } t_result;

    // up to two results produced for one item
    typedef struct packed {
        logic [1:0] push;
        t_result    slot0;
        t_result    slot1;
    } t_emit;

    function automatic logic [BASE_W-1:0] motif_byte(
        input logic [PATTERN_W-1:0]  pattern,
        input logic [BYTE_IDX_W-1:0] idx
    );
        motif_byte = pattern[{idx, 3'b000} +: BASE_W];
    endfunction

endpackage

@@ design/rsf_cell.sv @@
// ----------------------------------------------------------------------------
// rsf_cell
// One history cell: holds one base, passes it on, compares it to its motif byte.
// ----------------------------------------------------------------------------
module rsf_cell (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_shift,
    input  logic [rsf_pkg::BASE_W-1:0] i_d,
    input  logic [rsf_pkg::BASE_W-1:0] i_want,
    input  logic                      i_active,
    output logic [rsf_pkg::BASE_W-1:0] o_q,
    output logic                      o_hit
);

    logic [rsf_pkg::BASE_W-1:0] r_q;
    logic [rsf_pkg::BASE_W-1:0] n_q;

    always_comb begin
        n_q = i_shift ? i_d : r_q;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= '0;
        end else begin
            r_q <= n_q;
        end
    end

    // cells past the motif length always agree
    assign o_hit = !i_active || (r_q == i_want);
    assign o_q   = r_q;

endmodule

@@ design/rsf_cut.sv @@
// ----------------------------------------------------------------------------
// rsf_cut
// Cut evaluation: read position, last boundary, and fragment generation.
// ----------------------------------------------------------------------------
module rsf_cut #(
    parameter int MAX_READ_LEN = rsf_pkg::MAX_READ_LEN_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_advance,
    input  logic                          i_last,
    input  logic                          i_match,
    input  logic [rsf_pkg::CFG_LEN_W-1:0] i_motif_len,
    input  logic [rsf_pkg::CFG_LEN_W-1:0] i_cut_offset,
    output rsf_pkg::t_emit                o_emit
);

    localparam int POS_W = $clog2(MAX_READ_LEN + 1);
    localparam int BND_W = $clog2(MAX_READ_LEN);
    localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_READ_LEN);

    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] n_pos;
    logic [BND_W-1:0] r_bnd;
    logic [BND_W-1:0] n_bnd;

    logic                          in_range;
    logic [POS_W-1:0]              pos_n;
    logic [POS_W-1:0]              m_ext;
    logic [rsf_pkg::CFG_LEN_W-1:0] off;
    logic [POS_W-1:0]              cut;
    logic [POS_W-1:0]              bnd_ext;
    logic [POS_W-1:0]              bnd_mid;
    logic                          hit;
    logic                          cut_ok;
    logic                          fin_ok;
    rsf_pkg::t_result              cut_res;
    rsf_pkg::t_result              fin_res;

    always_comb begin
        // bases past the length limit are not counted
        in_range = r_pos < POS_LIMIT;
        pos_n    = in_range ? r_pos + POS_W'(1) : r_pos;
        m_ext    = POS_W'(i_motif_len);
        off      = (i_cut_offset > i_motif_len) ? i_motif_len : i_cut_offset;
        cut      = pos_n - m_ext + POS_W'(off);
        bnd_ext  = POS_W'(r_bnd);
        hit      = in_range && (pos_n >= m_ext) && i_match;
        // cut must lie strictly inside the read and beyond the last boundary
        cut_ok   = hit && (cut != '0) && (cut < POS_LIMIT)
                   && !(i_last && (cut == pos_n)) && (cut > bnd_ext);
        bnd_mid  = cut_ok ? cut : bnd_ext;
        fin_ok   = i_last && (pos_n > bnd_mid);

        cut_res.frag_start     = rsf_pkg::START_W'(r_bnd);
        cut_res.frag_length    = rsf_pkg::LEN_W'(cut - bnd_ext);
        cut_res.final_fragment = 1'b0;
        cut_res.run_last       = !fin_ok;

        fin_res.frag_start     = rsf_pkg::START_W'(bnd_mid);
        fin_res.frag_length    = rsf_pkg::LEN_W'(pos_n - bnd_mid);
        fin_res.final_fragment = 1'b1;
        fin_res.run_last       = 1'b1;

        o_emit.push  = i_advance ? {cut_ok & fin_ok, cut_ok ^ fin_ok} : 2'd0;
        o_emit.slot0 = cut_ok ? cut_res : fin_res;
        o_emit.slot1 = fin_res;
    end

    always_comb begin
        n_pos = r_pos;
        n_bnd = r_bnd;
        if (i_advance) begin
            if (i_last) begin
                n_pos = '0;
                n_bnd = '0;
            end else begin
                n_pos = pos_n;
                n_bnd = BND_W'(bnd_mid);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_bnd <= '0;
        end else begin
            r_pos <= n_pos;
            r_bnd <= n_bnd;
        end
    end

endmodule

@@ design/rsf_oq.sv @@
// ----------------------------------------------------------------------------
// rsf_oq
// Output queue: takes up to two results a cycle, hands out one when the reader is ready.
// ----------------------------------------------------------------------------
module rsf_oq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  rsf_pkg::t_emit   i_emit,
    output logic             o_room,
    output logic             o_valid,
    input  logic             i_ready,
    output rsf_pkg::t_result o_res
);

    rsf_pkg::t_result r_mem [rsf_pkg::OQ_DEPTH];

    logic [rsf_pkg::OQ_PTR_W-1:0] r_wr;
    logic [rsf_pkg::OQ_PTR_W-1:0] n_wr;
    logic [rsf_pkg::OQ_PTR_W-1:0] r_rd;
    logic [rsf_pkg::OQ_PTR_W-1:0] n_rd;
    logic [rsf_pkg::OQ_CNT_W-1:0] r_cnt;
    logic [rsf_pkg::OQ_CNT_W-1:0] n_cnt;
    logic [rsf_pkg::OQ_PTR_W-1:0] wr_next;
    logic                         pop;

    assign o_valid = (r_cnt != '0);
    assign pop     = o_valid && i_ready;
    assign wr_next = r_wr + rsf_pkg::OQ_PTR_W'(1);
    // room for a full pair
    assign o_room  = r_cnt <= rsf_pkg::OQ_CNT_W'(rsf_pkg::OQ_DEPTH - 2);
    assign o_res   = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr + rsf_pkg::OQ_PTR_W'(i_emit.push);
        n_rd  = r_rd + rsf_pkg::OQ_PTR_W'(pop);
        n_cnt = r_cnt + rsf_pkg::OQ_CNT_W'(i_emit.push) - rsf_pkg::OQ_CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_emit.push != 2'd0) begin
            r_mem[r_wr] <= i_emit.slot0;
        end
        if (i_emit.push == 2'd2) begin
            r_mem[wr_next] <= i_emit.slot1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

@@ design/restriction_site_fragmenter.sv @@
// ----------------------------------------------------------------------------
// restriction_site_fragmenter
// Streaming restriction digest: cuts a read at motif sites into fragments.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one base item per cycle
//   while o_in_ready is high, with i_read_end set on the final base of the read.
//   Output channel (o_out_valid / i_out_ready) carries fragments as start and
//   length; o_final_fragment marks the read's last fragment and o_run_last
//   marks the last fragment caused by one base item.
//   Config channel (i_cfg_valid / o_cfg_ready, always ready) writes motif
//   pattern, motif length and cut offset; write it only while idle.
// Path: a base item is registered in stage A; the fragments that it closes are
//   written into the output queue, which offers them on the output channel.
// Throughput: one base item per cycle while the output queue has room; the
//   motif cell row shifts once per accepted item and compares combinationally;
//   an item that yields two fragments occupies the single output port for both.
// Reset: clears position, boundary, history and queue, and restores the
//   GATC motif with length 4 and offset 0.
// Stall: a 4-entry output queue absorbs results; while it holds more than two,
//   the item in stage A waits and o_in_ready stays low until it drains.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module restriction_site_fragmenter #(
    parameter int MAX_MOTIF    = rsf_pkg::MAX_MOTIF_DEF,
    parameter int MAX_READ_LEN = rsf_pkg::MAX_READ_LEN_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // base items
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [rsf_pkg::BASE_W-1:0]    i_base,
    input  logic                          i_read_end,
    // fragment items
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [rsf_pkg::START_W-1:0]   o_frag_start,
    output logic [rsf_pkg::LEN_W-1:0]     o_frag_length,
    output logic                          o_final_fragment,
    output logic                          o_run_last,
    // configuration writes
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [rsf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [rsf_pkg::PATTERN_W-1:0] i_cfg_data
);

    // ---------------- configuration registers ----------------
    logic [rsf_pkg::PATTERN_W-1:0] r_cfg_pattern;
    logic [rsf_pkg::CFG_LEN_W-1:0] r_cfg_len;
    logic [rsf_pkg::CFG_LEN_W-1:0] r_cfg_off;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_pattern <= rsf_pkg::MOTIF_GATC;
            r_cfg_len     <= rsf_pkg::MOTIF_LEN_RST;
            r_cfg_off     <= rsf_pkg::CUT_OFFSET_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                rsf_pkg::CFG_MOTIF_PATTERN: r_cfg_pattern <= i_cfg_data;
                rsf_pkg::CFG_MOTIF_LENGTH:  r_cfg_len <= i_cfg_data[rsf_pkg::CFG_LEN_W-1:0];
                rsf_pkg::CFG_CUT_OFFSET:    r_cfg_off <= i_cfg_data[rsf_pkg::CFG_LEN_W-1:0];
                default: ; // unmapped index: write dropped
            endcase
        end
    end

    // effective motif length: zero acts as one, capped at the cell count
    logic [rsf_pkg::CFG_LEN_W-1:0] motif_len;

    always_comb begin
        if (r_cfg_len == '0) begin
            motif_len = rsf_pkg::CFG_LEN_W'(1);
        end else if (r_cfg_len > rsf_pkg::CFG_LEN_W'(MAX_MOTIF)) begin
            motif_len = rsf_pkg::CFG_LEN_W'(MAX_MOTIF);
        end else begin
            motif_len = r_cfg_len;
        end
    end

    // ---------------- stage A: base enters the cell row ----------------
    logic r_a_valid;
    logic n_a_valid;
    logic r_a_last;
    logic n_a_last;
    logic in_accept;
    logic advance;
    logic oq_room;

    assign advance    = r_a_valid && oq_room;
    assign o_in_ready = !r_a_valid || advance;
    assign in_accept  = i_in_valid && o_in_ready;

    always_comb begin
        n_a_valid = r_a_valid;
        n_a_last  = r_a_last;
        if (in_accept) begin
            n_a_valid = 1'b1;
            n_a_last  = i_read_end;
        end else if (advance) begin
            n_a_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_a_last  <= 1'b0;
        end else begin
            r_a_valid <= n_a_valid;
            r_a_last  <= n_a_last;
        end
    end

    // Cell k holds the base seen k items ago and compares it against motif
    // byte (len-1-k). The row shifts on every accepted item; stale bases from
    // an earlier read are masked by the position check downstream.
    logic [rsf_pkg::BASE_W-1:0] hist_q [MAX_MOTIF];
    logic [MAX_MOTIF-1:0]       cell_hit;

    for (genvar k = 0; k < MAX_MOTIF; k++) begin : g_cell
        logic [rsf_pkg::CFG_LEN_W-1:0] byte_sel;
        logic [rsf_pkg::BASE_W-1:0]    want;
        logic                          active;
        logic [rsf_pkg::BASE_W-1:0]    d_in;

        assign active   = rsf_pkg::CFG_LEN_W'(k) < motif_len;
        assign byte_sel = motif_len - rsf_pkg::CFG_LEN_W'(1) - rsf_pkg::CFG_LEN_W'(k);
        assign want     = rsf_pkg::motif_byte(r_cfg_pattern,
                                              byte_sel[rsf_pkg::BYTE_IDX_W-1:0]);

        if (k == 0) begin : g_head
            assign d_in = i_base;
        end else begin : g_link
            assign d_in = hist_q[k-1];
        end

        rsf_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_shift  (in_accept),
            .i_d      (d_in),
            .i_want   (want),
            .i_active (active),
            .o_q      (hist_q[k]),
            .o_hit    (cell_hit[k])
        );
    end

    // ---------------- stage B: cut evaluation ----------------
    rsf_pkg::t_emit emit;

    rsf_cut #(
        .MAX_READ_LEN (MAX_READ_LEN)
    ) u_cut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_advance    (advance),
        .i_last       (r_a_last),
        .i_match      (&cell_hit),
        .i_motif_len  (motif_len),
        .i_cut_offset (r_cfg_off),
        .o_emit       (emit)
    );

    // ---------------- output queue ----------------
    rsf_pkg::t_result out_res;

    rsf_oq u_oq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_emit  (emit),
        .o_room  (oq_room),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_res   (out_res)
    );

    assign o_frag_start     = out_res.frag_start;
    assign o_frag_length    = out_res.frag_length;
    assign o_final_fragment = out_res.final_fragment;
    assign o_run_last       = out_res.run_last;

    // ---------------- assertions ----------------
    // the read's closing fragment is always the last one of its item
    `ASSERT_SAME(a_final_is_run_last, i_clk, i_rst_n, o_out_valid && o_final_fragment, o_run_last)
    // a pair is always a cut fragment followed by the closing one
    `ASSERT_SAME(a_pair_order, i_clk, i_rst_n, emit.push == 2'd2, emit.slot1.final_fragment && !emit.slot0.run_last && !emit.slot0.final_fragment)
    // a held item keeps its slot and the cell row does not move under it
    `ASSERT_NEXT(a_hold_stage_a, i_clk, i_rst_n, r_a_valid && !advance, r_a_valid && $stable(hist_q[MAX_MOTIF-1]))

endmodule

@@ tb/restriction_site_fragmenter_test.sv @@
// ----------------------------------------------------------------------------
// restriction_site_fragmenter_test
// Streams reads into the fragmenter and checks every fragment it reports
// against an in-bench digest of the same bases. Covers directed corner reads
// and randomized reads across many motif settings, with random idling on
// both channels and one long output stall.
// ----------------------------------------------------------------------------
module restriction_site_fragmenter_test;

    localparam int MOTIF_MAX = rsf_pkg::MAX_MOTIF_DEF;
    localparam int READ_MAX  = rsf_pkg::MAX_READ_LEN_DEF;
    localparam int SETTLE_CYCLES = 8;   // drain time for bases that close no fragment
    localparam int STALL_CYCLES  = 400; // long output hold-off, fills the queue
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_ITEMS   = 125;

    localparam logic [rsf_pkg::BASE_W-1:0] NUCLEOTIDE [4] = '{8'h41, 8'h43, 8'h47, 8'h54};
    localparam logic [rsf_pkg::BASE_W-1:0] BASE_A = 8'h41;
    localparam rsf_pkg::t_cfg_idx CFG_UNMAPPED = rsf_pkg::t_cfg_idx'(3);

    typedef struct packed {
        logic [rsf_pkg::BASE_W-1:0] base;
        logic                       last;
    } t_base_item;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_in_valid = 1'b0;
    logic                          o_in_ready;
    logic [rsf_pkg::BASE_W-1:0]    i_base = '0;
    logic                          i_read_end = 1'b0;
    logic                          o_out_valid;
    logic                          i_out_ready = 1'b0;
    logic [rsf_pkg::START_W-1:0]   o_frag_start;
    logic [rsf_pkg::LEN_W-1:0]     o_frag_length;
    logic                          o_final_fragment;
    logic                          o_run_last;
    logic                          i_cfg_valid = 1'b0;
    logic                          o_cfg_ready;
    logic [rsf_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [rsf_pkg::PATTERN_W-1:0] i_cfg_data = '0;

    restriction_site_fragmenter dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_base          (i_base),
        .i_read_end      (i_read_end),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_frag_start    (o_frag_start),
        .o_frag_length   (o_frag_length),
        .o_final_fragment(o_final_fragment),
        .o_run_last      (o_run_last),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // shadow of the register file, tracked at each accepted write
    logic [rsf_pkg::PATTERN_W-1:0] motif_pat = rsf_pkg::MOTIF_GATC;
    logic [rsf_pkg::CFG_LEN_W-1:0] motif_len = rsf_pkg::MOTIF_LEN_RST;
    logic [rsf_pkg::CFG_LEN_W-1:0] cut_off   = rsf_pkg::CUT_OFFSET_RST;

    // digest state: recent bases (newest at 0), bases seen, last boundary
    logic [rsf_pkg::BASE_W-1:0]  recent [MOTIF_MAX] = '{default: '0};
    logic [rsf_pkg::LEN_W-1:0]   read_pos = '0;
    logic [rsf_pkg::START_W-1:0] boundary = '0;

    t_base_item       bases_to_send [$];
    rsf_pkg::t_result pending_frags [$];
    int               mismatches = 0;

    // flags from the stimulus sequence to the channel processes
    bit no_idle = 1'b0;
    bit stall_req = 1'b0;
    logic base_taken = 1'b0;

    // motif length as the block sees it: zero counts as one, clamp at max
    function automatic int unsigned eff_len();
        if (motif_len == 0) return 1;
        if (motif_len > MOTIF_MAX) return MOTIF_MAX;
        return motif_len;
    endfunction

    // Digest one accepted base: shift it in, look for the motif ending here,
    // and queue the fragments it closes (a cut fragment, then the final one).
    task automatic digest_base(input logic [rsf_pkg::BASE_W-1:0] b, input logic last);
        int unsigned m;
        int unsigned off;
        int unsigned cut;
        bit hit;
        bit ok;
        rsf_pkg::t_result frag;
        rsf_pkg::t_result burst [$];
        m = eff_len();
        // past the length limit bases are neither counted nor matched
        if (read_pos < READ_MAX) begin
            for (int k = MOTIF_MAX - 1; k > 0; k--) recent[k] = recent[k-1];
            recent[0] = b;
            read_pos++;
            // only bases of this read can complete a motif
            if (read_pos >= m) begin
                hit = 1'b1;
                for (int j = 0; j < m; j++)
                    if (recent[m-1-j] != motif_pat[8*j +: 8]) hit = 1'b0;
                if (hit) begin
                    off = (cut_off > m) ? m : cut_off;
                    cut = read_pos - m + off;
                    ok = (cut > 0) && (cut < READ_MAX);
                    // a cut right after the final base is no cut
                    if (last && cut >= read_pos) ok = 1'b0;
                    if (ok && cut > boundary) begin
                        frag.frag_start     = boundary;
                        frag.frag_length    = rsf_pkg::LEN_W'(cut - boundary);
                        frag.final_fragment = 1'b0;
                        frag.run_last       = 1'b0;
                        burst = {burst, frag};
                        boundary = cut[rsf_pkg::START_W-1:0];
                    end
                end
            end
        end
        if (last) begin
            if (read_pos > boundary) begin
                frag.frag_start     = boundary;
                frag.frag_length    = read_pos - boundary;
                frag.final_fragment = 1'b1;
                frag.run_last       = 1'b0;
                burst = {burst, frag};
            end
            read_pos = '0;
            boundary = '0;
        end
        if (burst.size() != 0) burst[burst.size()-1].run_last = 1'b1;
        pending_frags = {pending_frags, burst};
    endtask

    // Input side: hold an item until taken, otherwise offer the next or idle.
    always @(negedge i_clk) begin
        t_base_item nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (i_in_valid && !base_taken) begin
            // still waiting for acceptance, payload stays put
        end else if (bases_to_send.size() != 0 && (no_idle || $urandom_range(99) >= 20)) begin
            nxt = bases_to_send.pop_front();
            i_base     <= nxt.base;
            i_read_end <= nxt.last;
            i_in_valid <= 1'b1;
        end else begin
            i_in_valid <= 1'b0;
        end
    end

    // Output side: random backpressure plus one long hold-off on request.
    always @(negedge i_clk) begin
        int stall_left;
        bit stall_done;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else if (stall_req && !stall_done) begin
            stall_left = STALL_CYCLES;
            stall_done = 1'b1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= no_idle || ($urandom_range(99) >= 20);
        end
    end

    // Monitor: check each delivered fragment, then digest any accepted base.
    always @(posedge i_clk) begin
        rsf_pkg::t_result got;
        rsf_pkg::t_result want;
        if (!i_rst_n) begin
            base_taken <= 1'b0;
        end else begin
            base_taken <= i_in_valid && o_in_ready;
            if (o_out_valid && i_out_ready) begin
                got.frag_start     = o_frag_start;
                got.frag_length    = o_frag_length;
                got.final_fragment = o_final_fragment;
                got.run_last       = o_run_last;
                if (pending_frags.size() == 0) begin
                    $display("%0t: unexpected fragment exp none got start=%0d len=%0d fin=%0b last=%0b",
                             $time, got.frag_start, got.frag_length,
                             got.final_fragment, got.run_last);
                    mismatches++;
                end else begin
                    want = pending_frags.pop_front();
                    if (got !== want) begin
                        $display("%0t: fragment mismatch exp start=%0d len=%0d fin=%0b last=%0b",
                                 $time, want.frag_start, want.frag_length,
                                 want.final_fragment, want.run_last);
                        $display("%0t:                   got start=%0d len=%0d fin=%0b last=%0b",
                                 $time, got.frag_start, got.frag_length,
                                 got.final_fragment, got.run_last);
                        mismatches++;
                    end
                end
            end
            if (i_in_valid && o_in_ready) digest_base(i_base, i_read_end);
        end
    end

    task automatic write_reg(input rsf_pkg::t_cfg_idx idx,
                             input logic [rsf_pkg::PATTERN_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            rsf_pkg::CFG_MOTIF_PATTERN: motif_pat = data;
            rsf_pkg::CFG_MOTIF_LENGTH:  motif_len = data[rsf_pkg::CFG_LEN_W-1:0];
            rsf_pkg::CFG_CUT_OFFSET:    cut_off   = data[rsf_pkg::CFG_LEN_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Wait until every base is taken and every fragment seen, then let any
    // base that closes nothing drain through the pipeline.
    task automatic settle();
        while (bases_to_send.size() != 0 || i_in_valid || pending_frags.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic queue_literal(input string s);
        t_base_item it;
        for (int i = 0; i < s.len(); i++) begin
            it.base = s[i];
            it.last = (i == s.len() - 1);
            bases_to_send = {bases_to_send, it};
        end
    endtask

    // one-base read of an arbitrary byte value
    task automatic queue_byte(input logic [rsf_pkg::BASE_W-1:0] b);
        t_base_item it;
        it.base = b;
        it.last = 1'b1;
        bases_to_send = {bases_to_send, it};
    endtask

    // Random read of mostly nucleotides with motif copies planted in it.
    task automatic queue_read(input int len);
        logic [rsf_pkg::BASE_W-1:0] seq [$];
        t_base_item it;
        int m;
        int p;
        m = eff_len();
        for (int i = 0; i < len; i++)
            seq = {seq, (($urandom_range(99) < 5) ? rsf_pkg::BASE_W'($urandom)
                                                  : NUCLEOTIDE[$urandom_range(3)])};
        p = 0;
        while (p + m <= len) begin
            if ($urandom_range(99) < 10) begin
                for (int j = 0; j < m; j++) seq[p+j] = motif_pat[8*j +: 8];
                p += m;
            end else begin
                p++;
            end
        end
        for (int i = 0; i < len; i++) begin
            it.base = seq[i];
            it.last = (i == len - 1);
            bases_to_send = {bases_to_send, it};
        end
    endtask

    initial begin
        int queued;
        int len;
        logic [rsf_pkg::CFG_LEN_W-1:0] len_pick;
        logic [rsf_pkg::CFG_LEN_W-1:0] off_pick;
        logic [rsf_pkg::PATTERN_W-1:0] pat_pick;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Reset motif GATC, offset 0: a cut at zero is dropped, a motif split
        // over two reads does not match, a cut and the read end in one base,
        // and the extreme byte values as one-base reads.
        queue_literal("GATC");
        queue_literal("GA");
        queue_literal("TC");
        queue_literal("AAGATC");
        queue_byte(8'h00);
        queue_byte(8'hFF);
        settle();

        // Offset past the motif clamps to its length: a cut just after the
        // final base is dropped, one base earlier it splits the read.
        write_reg(rsf_pkg::CFG_CUT_OFFSET, 64'd15);
        queue_literal("AGATC");
        queue_literal("GATCA");
        settle();

        // Motif length zero acts as a one-base motif.
        write_reg(rsf_pkg::CFG_MOTIF_PATTERN, {56'd0, BASE_A});
        write_reg(rsf_pkg::CFG_MOTIF_LENGTH, 64'd0);
        queue_literal("AA");
        settle();

        // Random phases, extremes of length and offset first.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                0: len_pick = 4'd1;
                1: len_pick = 4'd8;
                2: len_pick = 4'd0;
                3: len_pick = 4'd15;
                default: len_pick = rsf_pkg::CFG_LEN_W'($urandom_range(15));
            endcase
            case (ph)
                0: off_pick = 4'd0;
                1: off_pick = 4'd8;
                2: off_pick = 4'd15;
                default: off_pick = rsf_pkg::CFG_LEN_W'($urandom_range(15));
            endcase
            if (ph % 3 == 0) begin
                pat_pick = {$urandom, $urandom};
            end else begin
                for (int j = 0; j < 8; j++) pat_pick[8*j +: 8] = NUCLEOTIDE[$urandom_range(3)];
            end
            write_reg(rsf_pkg::CFG_MOTIF_PATTERN, pat_pick);
            write_reg(rsf_pkg::CFG_MOTIF_LENGTH, {$urandom, $urandom} & ~64'hF | len_pick);
            write_reg(rsf_pkg::CFG_CUT_OFFSET, {60'd0, off_pick});
            // unmapped index: must leave the registers alone
            if (ph == 0) write_reg(CFG_UNMAPPED, {$urandom, $urandom});

            no_idle = (ph == 4);
            if (ph == 2) stall_req = 1'b1;

            queued = 0;
            while (queued < PHASE_ITEMS) begin
                len = ($urandom_range(9) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 20);
                queue_read(len);
                queued += len;
            end
            settle();
            no_idle = 1'b0;
        end

        settle();
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+design
design/rsf_pkg.sv
design/rsf_cell.sv
design/rsf_cut.sv
design/rsf_oq.sv
design/restriction_site_fragmenter.sv
tb/restriction_site_fragmenter_test.sv
